>>> hdl/feh_pkg.sv
`timescale 1ns / 1ps

package feh_pkg;

    // grid geometry
    localparam int GRID_SIZE = 16;
    localparam int IDX_W     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int MAX_EMIT  = 16;
    localparam int EMIT_N    = (GRID_SIZE < MAX_EMIT) ? GRID_SIZE : MAX_EMIT;

    // propagation weights
    localparam int W_OWN   = 10;
    localparam int W_BELOW = 12;
    localparam int W_SIDE  = 1;

    // weighted sum of one cell and its divisors
    localparam int SUM_W   = 13;
    localparam int DIV_W   = 5;
    localparam int DIV_S1  = W_OWN + W_SIDE;
    localparam int DIV_S2  = W_OWN + 2 * W_SIDE;
    localparam int DIV_BS1 = W_OWN + W_BELOW + W_SIDE;
    localparam int DIV_BS2 = W_OWN + W_BELOW + 2 * W_SIDE;

    // reciprocals for the divide, one correction step after the multiply
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 16;
    localparam int RECIP_S1    = (1 << RECIP_SHIFT) / DIV_S1;
    localparam int RECIP_S2    = (1 << RECIP_SHIFT) / DIV_S2;
    localparam int RECIP_BS1   = (1 << RECIP_SHIFT) / DIV_BS1;
    localparam int RECIP_BS2   = (1 << RECIP_SHIFT) / DIV_BS2;

    // palette ramp limits
    localparam int PAL_RED_END   = 85;
    localparam int PAL_GREEN_END = 170;
    localparam int PAL_STEP      = 3;

    // queue depths
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);
    localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

    // sequencer step counter covers the longest operation
    localparam int STEP_W = $clog2(GRID_SIZE + 4);

    typedef enum logic [1:0] {
        FN_COOL = 2'd0,
        FN_PROP = 2'd1,
        FN_SET  = 2'd2,
        FN_EMIT = 2'd3
    } func_e_t;

    typedef struct packed {
        func_e_t     func;
        logic [3:0]  col;
        logic [3:0]  row;
        logic [7:0]  amount;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  out_col;
        logic [3:0]  out_row;
        logic [23:0] color;
        logic        last;
    } out_item_t;

    typedef struct packed {
        func_e_t          op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [7:0]       amount;
        logic             has_below;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

    function automatic logic [DIV_W-1:0] div_of(input logic below, input logic both_sides);
        logic [DIV_W-1:0] d;
        if (below)
            d = both_sides ? DIV_W'(DIV_BS2) : DIV_W'(DIV_BS1);
        else
            d = both_sides ? DIV_W'(DIV_S2) : DIV_W'(DIV_S1);
        return d;
    endfunction

    function automatic logic [RECIP_W-1:0] recip_of(input logic below, input logic both_sides);
        logic [RECIP_W-1:0] m;
        if (below)
            m = both_sides ? RECIP_W'(RECIP_BS2) : RECIP_W'(RECIP_BS1);
        else
            m = both_sides ? RECIP_W'(RECIP_S2) : RECIP_W'(RECIP_S1);
        return m;
    endfunction

    // fire palette: red ramp, then green ramp, then blue ramp, white at the top
    function automatic logic [23:0] palette(input logic [7:0] h);
        logic [9:0]  t;
        logic [23:0] c;
        if (h < 8'(PAL_RED_END)) begin
            t = 10'(h) * 10'(PAL_STEP);
            c = {t[7:0], 8'h00, 8'h00};
        end
        else if (h < 8'(PAL_GREEN_END)) begin
            t = 10'(h - 8'(PAL_RED_END)) * 10'(PAL_STEP);
            c = {8'hFF, t[7:0], 8'h00};
        end
        else if (h != 8'hFF) begin
            t = 10'(h - 8'(PAL_GREEN_END)) * 10'(PAL_STEP);
            c = {8'hFF, 8'hFF, t[7:0]};
        end
        else begin
            t = '0;
            c = 24'hFFFFFF;
        end
        return c;
    endfunction

endpackage

>>> hdl/fire_effect_heat_grid.sv
`timescale 1ns / 1ps

// Fire effect heat grid: a 16 x 16 grid of 8-bit heat values with four operations.
// Input channel: push/full, one item per accepted push (func, col, row, amount).
//   cool and set change one cell, propagate rewrites one row from its neighbors,
//   emit reads one row out as 24-bit fire palette colors. Items whose cell or row
//   lies outside the grid are accepted and dropped.
// Result channel: empty/pop queue; only emit produces items, 16 per row with
//   last set on the final column. Colors come out in column order.
// Items pass through a two-entry command queue to a sequencer on the heat memory.
// The sequencer carries out one item at a time through its single write port on
//   the memory. Propagate runs a three-stage sum / reciprocal-multiply / correct
//   pipeline over the row one column per cycle.
// Emit path: an accepted item passes the command queue, the sequencer, the
//   registered memory read and the result queue before its first color shows.
// Reset: the heat memory is swept to zero, one cell a cycle, while full stays
//   high; nothing is lost, items simply wait.
// A stalled receiver fills the four-entry result queue; emit then pauses and
//   the command queue backs up until full rises.

module fire_effect_heat_grid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  feh_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output feh_pkg::out_item_t result
);
    import feh_pkg::*;

    // front to back command path
    cmd_chan_t            cmd_chan;
    logic                 cmd_pop;
    logic                 clearing;

    // back to result queue
    logic                 res_push;
    out_item_t            res_item;
    logic [RES_CNT_W-1:0] res_count;

    // accepts items, drops out-of-range ones, queues the rest
    feh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .clearing (clearing),
        .cmd_chan (cmd_chan),
        .cmd_pop  (cmd_pop)
    );

    // heat memory and the sequencer that carries out each command
    feh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_chan  (cmd_chan),
        .cmd_pop   (cmd_pop),
        .clearing  (clearing),
        .res_push  (res_push),
        .res_item  (res_item),
        .res_count (res_count)
    );

    // colors wait here until the receiver pops them
    feh_res_queue u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res_item  (res_item),
        .res_count (res_count),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

>>> hdl/feh_front.sv
`timescale 1ns / 1ps

module feh_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  feh_pkg::in_item_t  item,
    input  logic               clearing,
    output feh_pkg::cmd_chan_t cmd_chan,
    input  logic               cmd_pop
);
    import feh_pkg::*;

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;

    logic accept;
    logic keep;
    logic cell_ok;
    logic row_ok;
    logic do_wr;
    logic do_rd;
    cmd_t cmd_in;

    // range checks; items that touch nothing never reach the back end
    always_comb
    begin
        cell_ok = (int'(item.col) < GRID_SIZE) && (int'(item.row) < GRID_SIZE);
        row_ok  = int'(item.row) < GRID_SIZE;
        unique case (item.func)
            FN_COOL, FN_SET: keep = cell_ok;
            FN_PROP, FN_EMIT: keep = row_ok;
            default: keep = 1'b0;
        endcase
        cmd_in.op        = item.func;
        cmd_in.row       = IDX_W'(item.row);
        cmd_in.col       = IDX_W'(item.col);
        cmd_in.amount    = item.amount;
        cmd_in.has_below = (int'(item.row) + 1) < GRID_SIZE;
    end

    assign full   = clearing || (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign accept = push && !full;
    assign do_wr  = accept && keep;
    assign do_rd  = cmd_pop && (cnt_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_wr && do_rd)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            q_reg[wr_ptr_reg] <= cmd_in;
    end

    assign cmd_chan.valid = (cnt_reg != '0);
    assign cmd_chan.cmd   = q_reg[rd_ptr_reg];

endmodule

>>> hdl/feh_back.sv
`timescale 1ns / 1ps

module feh_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  feh_pkg::cmd_chan_t             cmd_chan,
    output logic                           cmd_pop,
    output logic                           clearing,
    output logic                           res_push,
    output feh_pkg::out_item_t             res_item,
    input  logic [feh_pkg::RES_CNT_W-1:0]  res_count
);
    import feh_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_COOL  = 6'b000100,
        ST_SET   = 6'b001000,
        ST_PROP  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;

    // heat memory: one write port, two registered read ports
    logic [7:0]          heat_mem [MEM_DEPTH];
    logic [7:0]          rd_a;
    logic [7:0]          rd_b;
    logic [ADDR_W-1:0]   rd_addr_a;
    logic [ADDR_W-1:0]   rd_addr_b;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [7:0]          wr_data;

    // emit tracking
    logic                em_issue;
    logic                em_v_reg;
    logic [IDX_W-1:0]    em_col_reg;
    logic [RES_CNT_W:0]  em_used;

    // propagate window and divide pipeline
    logic [IDX_W-1:0]    step_col;
    logic [IDX_W-1:0]    below_row;
    logic [7:0]          left_reg, cur_reg, below_reg;
    logic                win_shift;
    logic                calc;
    logic [IDX_W-1:0]    calc_col;
    logic                has_left, has_right;
    logic [SUM_W-1:0]    sum;
    logic                s1_v_reg;
    logic [SUM_W-1:0]    s1_sum_reg;
    logic                s1_below_reg, s1_both_reg;
    logic [IDX_W-1:0]    s1_col_reg;
    logic [SUM_W+RECIP_W-1:0] s1_prod;
    logic                s2_v_reg;
    logic [7:0]          s2_q_reg;
    logic [SUM_W-1:0]    s2_sum_reg;
    logic                s2_below_reg, s2_both_reg;
    logic [IDX_W-1:0]    s2_col_reg;
    logic [DIV_W-1:0]    s2_div;
    logic [SUM_W-1:0]    s2_rem;
    logic [7:0]          q_fix;

    assign step_col  = step_reg[IDX_W-1:0];
    assign below_row = cmd_reg.row + IDX_W'(1);
    assign clearing  = (state_reg == ST_CLEAR);
    assign em_used   = (RES_CNT_W + 1)'(res_count) + (RES_CNT_W + 1)'(em_v_reg);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        clr_cnt_next = clr_cnt_reg;
        cmd_pop      = 1'b0;
        em_issue     = 1'b0;
        rd_addr_a    = {cmd_reg.row, cmd_reg.col};
        rd_addr_b    = {below_row, step_col};
        wr_en        = 1'b0;
        wr_addr      = {cmd_reg.row, cmd_reg.col};
        wr_data      = 8'd0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {ADDR_W{1'b1}})
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                step_next = '0;
                if (cmd_chan.valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd_chan.cmd.op)
                        FN_COOL: state_next = ST_COOL;
                        FN_PROP: state_next = ST_PROP;
                        FN_SET:  state_next = ST_SET;
                        FN_EMIT: state_next = ST_EMIT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_COOL:
            begin
                // read the cell, then write it back cooled
                if (step_reg == '0)
                    step_next = STEP_W'(1);
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = (rd_a > cmd_reg.amount) ? rd_a - cmd_reg.amount : 8'd0;
                    state_next = ST_IDLE;
                end
            end
            ST_SET:
            begin
                wr_en      = 1'b1;
                wr_data    = cmd_reg.amount;
                state_next = ST_IDLE;
            end
            ST_PROP:
            begin
                rd_addr_a = {cmd_reg.row, step_col};
                wr_en     = s2_v_reg;
                wr_addr   = {cmd_reg.row, s2_col_reg};
                wr_data   = q_fix;
                if (step_reg == STEP_W'(GRID_SIZE + 3))
                    state_next = ST_IDLE;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_EMIT:
            begin
                rd_addr_a = {cmd_reg.row, step_col};
                // only read a cell when the result queue has room for it
                em_issue  = (step_reg < STEP_W'(EMIT_N)) &&
                            (em_used < (RES_CNT_W + 1)'(RES_DEPTH));
                if (em_issue)
                    step_next = step_reg + 1'b1;
                if ((step_reg == STEP_W'(EMIT_N)) && !em_v_reg)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            step_reg    <= '0;
            clr_cnt_reg <= '0;
            em_v_reg    <= 1'b0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            clr_cnt_reg <= clr_cnt_next;
            em_v_reg    <= em_issue;
            s1_v_reg    <= calc;
            s2_v_reg    <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            heat_mem[wr_addr] <= wr_data;
        rd_a <= heat_mem[rd_addr_a];
        rd_b <= heat_mem[rd_addr_b];
    end

    // window: cur holds column step-2, rd_a brings its right neighbor
    assign win_shift = (state_reg == ST_PROP) && (step_reg >= STEP_W'(1)) &&
                       (step_reg <= STEP_W'(GRID_SIZE));
    assign calc      = (state_reg == ST_PROP) && (step_reg >= STEP_W'(2)) &&
                       (step_reg <= STEP_W'(GRID_SIZE + 1));
    assign calc_col  = IDX_W'(step_reg - STEP_W'(2));
    assign has_left  = (calc_col != '0);
    assign has_right = (calc_col != IDX_W'(GRID_SIZE - 1));

    always_comb
    begin
        sum = SUM_W'(W_OWN) * SUM_W'(cur_reg);
        if (cmd_reg.has_below)
            sum = sum + SUM_W'(W_BELOW) * SUM_W'(below_reg);
        if (has_left)
            sum = sum + SUM_W'(W_SIDE) * SUM_W'(left_reg);
        if (has_right)
            sum = sum + SUM_W'(W_SIDE) * SUM_W'(rd_a);
    end

    assign s1_prod = (SUM_W + RECIP_W)'(s1_sum_reg) *
                     (SUM_W + RECIP_W)'(recip_of(s1_below_reg, s1_both_reg));

    // estimate is exact or one low
    assign s2_div = div_of(s2_below_reg, s2_both_reg);
    assign s2_rem = s2_sum_reg - SUM_W'(SUM_W'(s2_q_reg) * SUM_W'(s2_div));
    assign q_fix  = (s2_rem >= SUM_W'(s2_div)) ? s2_q_reg + 8'd1 : s2_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cmd_reg <= cmd_chan.cmd;
        if (em_issue)
            em_col_reg <= step_col;
        if (win_shift)
        begin
            left_reg  <= cur_reg;
            cur_reg   <= rd_a;
            below_reg <= rd_b;
        end
        s1_sum_reg   <= sum;
        s1_below_reg <= cmd_reg.has_below;
        s1_both_reg  <= has_left && has_right;
        s1_col_reg   <= calc_col;
        s2_q_reg     <= 8'(s1_prod >> RECIP_SHIFT);
        s2_sum_reg   <= s1_sum_reg;
        s2_below_reg <= s1_below_reg;
        s2_both_reg  <= s1_both_reg;
        s2_col_reg   <= s1_col_reg;
    end

    assign res_push         = em_v_reg;
    assign res_item.out_col = 4'(em_col_reg);
    assign res_item.out_row = 4'(cmd_reg.row);
    assign res_item.color   = palette(rd_a);
    assign res_item.last    = (em_col_reg == IDX_W'(EMIT_N - 1));

endmodule

>>> hdl/feh_res_queue.sv
`timescale 1ns / 1ps

module feh_res_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           res_push,
    input  feh_pkg::out_item_t             res_item,
    output logic [feh_pkg::RES_CNT_W-1:0]  res_count,
    output logic                           empty,
    input  logic                           pop,
    output feh_pkg::out_item_t             result
);
    import feh_pkg::*;

    out_item_t            q_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 do_wr;
    logic                 do_rd;

    assign do_wr = res_push && (cnt_reg != RES_CNT_W'(RES_DEPTH));
    assign do_rd = pop && (cnt_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_wr && do_rd)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            q_reg[wr_ptr_reg] <= res_item;
    end

    assign res_count = cnt_reg;
    assign empty     = (cnt_reg == '0);
    assign result    = q_reg[rd_ptr_reg];

endmodule

>>> sim/fire_effect_heat_grid_tb.sv
`timescale 1ns / 1ps

module fire_effect_heat_grid_tb;

    import feh_pkg::*;

    // run shape
    localparam int RANDOM_ITEMS = 120;
    localparam int IDLE_LIMIT   = 3000;   // reset sweep, longest stall and a propagate, with margin
    localparam int TAIL_CYCLES  = 60;     // settling time at the end for any late extra colors
    localparam int MAX_REPORTS  = 100;

    // palette ramp points
    localparam int RAMP_RED_END   = 85;
    localparam int RAMP_GREEN_END = 170;
    localparam int RAMP_STEP      = 3;

    // propagation weights
    localparam int WT_OWN   = 10;
    localparam int WT_BELOW = 12;
    localparam int WT_SIDE  = 1;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      full;
    in_item_t  item  = '0;
    logic      empty;
    logic      pop   = 1'b0;
    out_item_t result;

    // predictor state: the heat grid as the block should hold it
    logic [7:0] heat_model [GRID_SIZE*GRID_SIZE];
    out_item_t  expected_colors [$];
    out_item_t  want_px;

    int errors      = 0;
    int items_sent  = 0;
    int colors_seen = 0;
    int func_count [4];
    int burst_left  = 0;
    int idle_cycles = 0;
    int rx_cycle    = 0;

    fire_effect_heat_grid uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    // fire palette: red ramp, green ramp, blue ramp, white at full heat
    function automatic logic [23:0] heat_to_rgb(input logic [7:0] h);
        int v;
        v = h;
        if (v < RAMP_RED_END)
            return {8'(RAMP_STEP * v), 16'h0000};
        else if (v < RAMP_GREEN_END)
            return {8'hFF, 8'(RAMP_STEP * (v - RAMP_RED_END)), 8'h00};
        else if (v < 255)
            return {16'hFFFF, 8'(RAMP_STEP * (v - RAMP_GREEN_END))};
        else
            return 24'hFFFFFF;
    endfunction

    // weighted average of each cell with the row below and its side neighbors;
    // missing neighbors drop out of the divisor, all reads see the old row
    task automatic spread_row(input int r);
        logic [7:0] fresh [GRID_SIZE];
        int sum;
        int div;
        for (int c = 0; c < GRID_SIZE; c++)
        begin
            sum = WT_OWN * heat_model[r*GRID_SIZE + c];
            div = WT_OWN;
            if (r + 1 < GRID_SIZE)
            begin
                sum += WT_BELOW * heat_model[(r+1)*GRID_SIZE + c];
                div += WT_BELOW;
            end
            if (c > 0)
            begin
                sum += WT_SIDE * heat_model[r*GRID_SIZE + c - 1];
                div += WT_SIDE;
            end
            if (c + 1 < GRID_SIZE)
            begin
                sum += WT_SIDE * heat_model[r*GRID_SIZE + c + 1];
                div += WT_SIDE;
            end
            fresh[c] = 8'(sum / div);
        end
        for (int c = 0; c < GRID_SIZE; c++)
            heat_model[r*GRID_SIZE + c] = fresh[c];
    endtask

    // apply one accepted item to the model grid, queue any colors it yields
    task automatic heat_grid_step(input in_item_t it);
        int r;
        int c;
        int h;
        logic cell_ok;
        logic row_ok;
        out_item_t px;
        r = it.row;
        c = it.col;
        row_ok  = (r < GRID_SIZE);
        cell_ok = row_ok && (c < GRID_SIZE);
        case (it.func)
            FN_COOL:
                if (cell_ok)
                begin
                    h = heat_model[r*GRID_SIZE + c];
                    heat_model[r*GRID_SIZE + c] = (h > it.amount) ? 8'(h - it.amount) : 8'd0;
                end
            FN_PROP:
                if (row_ok)
                    spread_row(r);
            FN_SET:
                if (cell_ok)
                    heat_model[r*GRID_SIZE + c] = it.amount;
            FN_EMIT:
                if (row_ok)
                    for (int k = 0; k < EMIT_N; k++)
                    begin
                        px.out_col = 4'(k);
                        px.out_row = 4'(r);
                        px.color   = heat_to_rgb(heat_model[r*GRID_SIZE + k]);
                        px.last    = (k == EMIT_N - 1);
                        expected_colors.push_back(px);
                    end
        endcase
    endtask

    // ---------------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------------

    function automatic in_item_t make_item(input func_e_t f, input int r, input int c,
                                           input int amt);
        in_item_t it;
        it.func   = f;
        it.row    = 4'(r);
        it.col    = 4'(c);
        it.amount = 8'(amt);
        return it;
    endfunction

    // offer one item and hold it until accepted; bursts end in a random gap
    task automatic send_item(input in_item_t it);
        int gap;
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
        heat_grid_step(it);
        func_count[it.func]++;
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
            gap = $urandom_range(1, 8);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off the sender until every expected color has been taken
    task automatic wait_drain();
        push <= 1'b0;
        do @(posedge clk); while (expected_colors.size() != 0);
    endtask

    // ---------------------------------------------------------------------
    // receiver side: stall pattern cycles through four modes
    // ---------------------------------------------------------------------

    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 80) % 4)
            0:       pop <= 1'b1;                             // take everything
            1:       pop <= ($urandom_range(0, 1) == 0);      // coin flip
            2:       pop <= ((rx_cycle % 4) == 0);            // one in four
            default: pop <= ((rx_cycle % 40) >= 25);          // long stalls, fills result queue
        endcase
    end

    // ---------------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // compare every taken color against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            colors_seen++;
            if (expected_colors.size() == 0)
                report_mismatch($sformatf("color item with nothing expected (col %0d row %0d)",
                                          result.out_col, result.out_row));
            else
            begin
                want_px = expected_colors.pop_front();
                if (result.out_col !== want_px.out_col)
                    report_mismatch($sformatf("out_col got %0d want %0d (row %0d)",
                                              result.out_col, want_px.out_col, want_px.out_row));
                if (result.out_row !== want_px.out_row)
                    report_mismatch($sformatf("out_row got %0d want %0d (col %0d)",
                                              result.out_row, want_px.out_row, want_px.out_col));
                if (result.color !== want_px.color)
                    report_mismatch($sformatf("color got %06h want %06h (row %0d col %0d)",
                                              result.color, want_px.color,
                                              want_px.out_row, want_px.out_col));
                if (result.last !== want_px.last)
                    report_mismatch($sformatf("last got %0b want %0b (row %0d col %0d)",
                                              result.last, want_px.last,
                                              want_px.out_row, want_px.out_col));
            end
        end
    end

    // watchdog: too long with no item moving on either side ends the run
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
            $display("** fire_effect_heat_grid: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // every ramp boundary of the palette in one row, then read it out
    task automatic test_palette_ramps();
        int heats [10] = '{0, 1, 84, 85, 86, 169, 170, 171, 254, 255};
        for (int c = 0; c < 10; c++)
            send_item(make_item(FN_SET, 3, c, heats[c]));
        send_item(make_item(FN_EMIT, 3, 0, 0));
    endtask

    // cooling by nothing, by part, and past zero so it saturates
    task automatic test_cool_saturation();
        send_item(make_item(FN_SET, 5, 0, 255));
        send_item(make_item(FN_COOL, 5, 0, 0));
        send_item(make_item(FN_COOL, 5, 0, 100));
        send_item(make_item(FN_SET, 5, 15, 7));
        send_item(make_item(FN_COOL, 5, 15, 255));
        send_item(make_item(FN_EMIT, 5, 15, 255));
    endtask

    // bottom row and both edge columns lose weights from the divisor
    task automatic test_propagate_edges();
        send_item(make_item(FN_SET, 15, 0, 200));
        send_item(make_item(FN_SET, 15, 15, 255));
        send_item(make_item(FN_SET, 14, 0, 100));
        send_item(make_item(FN_SET, 14, 15, 30));
        send_item(make_item(FN_PROP, 14, 0, 0));
        send_item(make_item(FN_PROP, 15, 15, 255));
        send_item(make_item(FN_EMIT, 14, 0, 0));
        send_item(make_item(FN_EMIT, 15, 0, 0));
    endtask

    // frames of a running fire: sparks, cooling, a top-down sweep of rows and
    // a read-out, mixed with fully random noise items
    task automatic test_random_fire();
        int start_count;
        int n;
        int r0;
        int r_end;
        bit paused;
        start_count = items_sent;
        paused = 1'b0;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            // halfway through, let the block run dry once
            if (!paused && (items_sent - start_count >= RANDOM_ITEMS / 2))
            begin
                wait_drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 8)
            begin
                // sparks mostly along the bottom row
                n = $urandom_range(1, 4);
                repeat (n)
                    send_item(make_item(FN_SET,
                                        ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : 15,
                                        $urandom_range(0, 15), $urandom_range(0, 255)));
                n = $urandom_range(0, 3);
                repeat (n)
                    send_item(make_item(FN_COOL, $urandom_range(0, 15), $urandom_range(0, 15),
                                        ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31)
                                                                    : $urandom_range(0, 255)));
                // rows go top to bottom so below is still the old row
                r0 = $urandom_range(0, 15);
                r_end = r0 + $urandom_range(0, 5);
                if (r_end > 15)
                    r_end = 15;
                for (int r = r0; r <= r_end; r++)
                    send_item(make_item(FN_PROP, r, $urandom_range(0, 15),
                                        $urandom_range(0, 255)));
                n = $urandom_range(1, 2);
                repeat (n)
                    send_item(make_item(FN_EMIT, $urandom_range(0, 15), $urandom_range(0, 15),
                                        $urandom_range(0, 255)));
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_item(make_item(func_e_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                                        $urandom_range(0, 15), $urandom_range(0, 255)));
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------

    initial
    begin
        foreach (heat_model[i])
            heat_model[i] = 8'd0;
        foreach (func_count[i])
            func_count[i] = 0;

        // reset held low first; the block then sweeps its grid with full high
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_palette_ramps();
        wait_drain();
        test_cool_saturation();
        wait_drain();
        test_propagate_edges();
        wait_drain();
        test_random_fire();

        // all sent: wait for the last colors, then let any late extras show up
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_colors.size() != 0)
            report_mismatch($sformatf("%0d expected color items never arrived",
                                      expected_colors.size()));

        $display("covered %0d items: %0d set, %0d cool, %0d propagate, %0d emit",
                 items_sent, func_count[FN_SET], func_count[FN_COOL],
                 func_count[FN_PROP], func_count[FN_EMIT]);
        $display("%0d color items checked, %0d mismatches", colors_seen, errors);
        if (errors == 0)
            $display("** fire_effect_heat_grid: PASSED **");
        else
            $display("** fire_effect_heat_grid: FAILED **");
        $finish;
    end

endmodule
